@@ src/upd_pkg.sv @@
// Shared types and character constants for the URL percent decoder.
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One decoded group: up to three output bytes produced by one input word.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       esc;
    logic       last;
  } upd_cmd_t;

endpackage

@@ src/url_percent_decoder_top.sv @@
// Top level of the streaming URL percent decoder.
//
// The input channel takes one encoded character per word (in_byte, with
// in_last marking the end of a string). The output channel delivers decoded
// characters, one per word, with out_last on the final character of a string
// and out_from_escape set when the byte came from a complete %XY escape.
// A plus becomes a space, and malformed escapes are passed through literally.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low.
// The front end classifies each input word in the same cycle and pushes the
// one to three resulting characters, if any, as one group into a four-entry
// queue. The back end drains the queue through an output register, so a
// character passes through its queue entry and then that register.
// One input word is taken per cycle while each word yields at most one
// character and out_stall is low; a flushed escape's characters leave one by
// one, and the queue absorbs those bursts. in_stall rises only when the queue
// is full: when out_stall holds the output back or flushes pile up.
// Reset clears the escape state, empties the queue and drops the output word.
module url_percent_decoder_top import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_from_escape
);

  logic     accept;
  logic     push;
  upd_cmd_t push_cmd;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  upd_cmd_t q_head;

  // Input words are taken whenever the queue has room for a group.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .cmd     (push_cmd)
  );

  upd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  upd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_from_escape (out_from_escape)
  );

endmodule

@@ src/upd_front.sv @@
// Front end: tracks the escape state and turns each input word into a group.
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push,
  output upd_cmd_t   cmd
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIG_UP = 2'd2,
    PH_DIG_LO = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;

  logic       is_hex;
  logic [3:0] hv;
  logic       idle_emit;
  logic [7:0] idle_char;
  phase_t     idle_next;
  logic [7:0] digit_char;

  always_comb begin
    is_hex = 1'b1;
    hv     = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hv = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hv = 4'(in_byte - 8'h37);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hv = 4'(in_byte - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  // How a byte is handled with no escape pending.
  always_comb begin
    idle_emit = !(in_byte == CH_PERCENT && !in_last);
    idle_char = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    idle_next = (in_byte == CH_PERCENT && !in_last) ? PH_PCT : PH_IDLE;
  end

  // The held digit, restored in its original case.
  always_comb begin
    if (nib_r < 4'd10) begin
      digit_char = 8'h30 + {4'd0, nib_r};
    end else if (phase_r == PH_DIG_LO) begin
      digit_char = 8'h57 + {4'd0, nib_r};
    end else begin
      digit_char = 8'h37 + {4'd0, nib_r};
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.last  = in_last;
    phase_nxt = PH_IDLE;
    nib_nxt   = nib_r;
    unique case (phase_r)
      PH_IDLE: begin
        cmd.cnt   = {1'b0, idle_emit};
        cmd.b0    = idle_char;
        phase_nxt = idle_next;
      end
      PH_PCT: begin
        if (is_hex) begin
          if (in_last) begin
            cmd.cnt = 2'd2;
            cmd.b0  = CH_PERCENT;
            cmd.b1  = in_byte;
          end else begin
            nib_nxt   = hv;
            phase_nxt = (in_byte >= 8'h61) ? PH_DIG_LO : PH_DIG_UP;
          end
        end else begin
          cmd.cnt   = 2'd1 + {1'b0, idle_emit};
          cmd.b0    = CH_PERCENT;
          cmd.b1    = idle_char;
          phase_nxt = idle_next;
        end
      end
      PH_DIG_UP, PH_DIG_LO: begin
        if (is_hex) begin
          cmd.cnt = 2'd1;
          cmd.b0  = {nib_r, hv};
          cmd.esc = 1'b1;
        end else begin
          cmd.cnt   = 2'd2 + {1'b0, idle_emit};
          cmd.b0    = CH_PERCENT;
          cmd.b1    = digit_char;
          cmd.b2    = idle_char;
          phase_nxt = idle_next;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (in_last) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign push = accept && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      nib_r   <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule

@@ src/upd_queue.sv @@
// Small FIFO of decoded groups between the front and back ends.
module upd_queue import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  upd_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output upd_cmd_t head
);

  upd_cmd_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ src/upd_back.sv @@
// Back end: walks each group and emits its bytes one word per cycle while out_stall is low.
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  upd_cmd_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_from_escape
);

  logic [1:0] idx_r;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       esc_r;

  logic       load;
  logic       at_end;
  logic [7:0] sel_byte;

  assign load   = q_valid && (!valid_r || !out_stall);
  assign at_end = (idx_r == (q_head.cnt - 2'd1));
  assign q_pop  = load && at_end;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = q_head.b0;
      2'd1:    sel_byte = q_head.b1;
      default: sel_byte = q_head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      last_r <= q_head.last && at_end;
      esc_r  <= q_head.esc && (idx_r == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= at_end ? 2'd0 : idx_r + 2'd1;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_last        = last_r;
  assign out_from_escape = esc_r;

endmodule

@@ dv/upd_decode_checker.sv @@
// Checker that predicts the decoded character stream and compares it with the output channel.
`timescale 1ns / 1ps

module upd_decode_checker import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       out_from_escape,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PCT,
    ESC_DIG_UP,
    ESC_DIG_LO
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       esc;
  } dec_word_t;

  localparam logic [7:0] CH_DIG0    = 8'h30;
  localparam logic [7:0] CH_DIG9    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [4:0] NOT_HEX    = 5'd16;
  localparam int         PRINT_CAP  = 50;

  esc_phase_e  phase_q = ESC_NONE;
  logic [3:0]  nibble_q = 4'h0;
  dec_word_t   decoded_q[$];
  dec_word_t   group_q[$];
  int          n_fail = 0;
  int          n_checked = 0;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_DIG0 && c <= CH_DIG9) begin
      v = c - CH_DIG0;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = c - CH_UPPER_A + 8'd10;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = c - CH_LOWER_A + 8'd10;
    end else begin
      return NOT_HEX;
    end
    return v[4:0];
  endfunction

  task automatic add_char(input logic [7:0] c, input logic esc);
    dec_word_t w;
    w.ch = c;
    w.last = 1'b0;
    w.esc = esc;
    group_q.push_back(w);
  endtask

  // Handles a character with no escape pending.
  task automatic plain_char(input logic [7:0] c, input logic lst);
    if (c == CH_PERCENT) begin
      if (lst) begin
        add_char(CH_PERCENT, 1'b0);
      end else begin
        phase_q = ESC_PCT;
      end
    end else if (c == CH_PLUS) begin
      add_char(CH_SPACE, 1'b0);
    end else begin
      add_char(c, 1'b0);
    end
  endtask

  task automatic decode_word(input logic [7:0] c, input logic lst);
    esc_phase_e held;
    logic [4:0] hv;
    logic [7:0] digit;
    dec_word_t  tail;
    held = phase_q;
    hv = hex_val(c);
    phase_q = ESC_NONE;
    group_q.delete();
    case (held)
      ESC_NONE: begin
        plain_char(c, lst);
      end
      ESC_PCT: begin
        if (hv != NOT_HEX) begin
          if (lst) begin
            add_char(CH_PERCENT, 1'b0);
            add_char(c, 1'b0);
          end else begin
            nibble_q = hv[3:0];
            phase_q = (c >= CH_LOWER_A) ? ESC_DIG_LO : ESC_DIG_UP;
          end
        end else begin
          add_char(CH_PERCENT, 1'b0);
          plain_char(c, lst);
        end
      end
      default: begin
        if (hv != NOT_HEX) begin
          add_char({nibble_q, hv[3:0]}, 1'b1);
        end else begin
          // The held digit is replayed in the case it arrived in.
          if (nibble_q < 4'd10) begin
            digit = CH_DIG0 + nibble_q;
          end else if (held == ESC_DIG_LO) begin
            digit = CH_LOWER_A + nibble_q - 8'd10;
          end else begin
            digit = CH_UPPER_A + nibble_q - 8'd10;
          end
          add_char(CH_PERCENT, 1'b0);
          add_char(digit, 1'b0);
          plain_char(c, lst);
        end
      end
    endcase
    if (lst) begin
      phase_q = ESC_NONE;
      if (group_q.size() > 0) begin
        tail = group_q.pop_back();
        tail.last = 1'b1;
        group_q.push_back(tail);
      end
    end
    while (group_q.size() > 0) begin
      decoded_q.push_back(group_q.pop_front());
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (n_fail < PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %h, expected %h (decoded word %0d)",
               $realtime, what, got, want, n_checked);
    end
    n_fail++;
  endtask

  always @(posedge clk) begin
    dec_word_t head;
    if (!rst_n) begin
      phase_q = ESC_NONE;
      nibble_q = 4'h0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        decode_word(in_byte, in_last);
      end
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("word with nothing expected", out_byte, 8'h00);
        end else begin
          head = decoded_q.pop_front();
          if (out_byte !== head.ch) begin
            report_mismatch("out_byte", out_byte, head.ch);
          end
          if (out_last !== head.last) begin
            report_mismatch("out_last", {7'd0, out_last}, {7'd0, head.last});
          end
          if (out_from_escape !== head.esc) begin
            report_mismatch("out_from_escape", {7'd0, out_from_escape}, {7'd0, head.esc});
          end
          n_checked++;
        end
      end
    end
    pending    <= decoded_q.size();
    fail_count <= n_fail;
    checked    <= n_checked;
  end

endmodule

@@ dv/url_percent_decoder_top_tb.sv @@
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module url_percent_decoder_top_tb import upd_pkg::*;;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  // The limit leaves a wide margin over the length of a legal run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 130;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_from_escape;

  int fail_count;
  int pending;
  int checked;

  // Per-cycle idle chances, in percent, for the sender and the receiver.
  int send_idle = 0;
  int recv_idle = 0;

  // The long output hold-off runs in its own process once hold_go is set.
  bit   hold_go = 1'b0;
  logic hold_on = 1'b0;

  int words_sent = 0;
  int strings_sent = 0;
  int cycle_cnt = 0;

  logic [7:0] text_q[$];
  string      hex_chars = "0123456789ABCDEFabcdef";
  string      stray_chars = "gGzZ =&/?.-_~";

  url_percent_decoder_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_from_escape (out_from_escape)
  );

  upd_decode_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_from_escape (out_from_escape),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Reset is held low from the start and released on a falling edge,
  // well away from the edge where the block samples it.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // The receiver decides its stall on every falling edge. During the hold-off
  // it refuses every word, so the block's queue fills and in_stall rises.
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle);
  end

  // The hold-off is counted here, independent of how the sender is doing.
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Run stopped after %0d cycles with %0d words still expected.",
             CYCLE_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one word, possibly after idle cycles, and returns on the
  // falling edge after the rising edge that accepted it. Valid stays high on
  // return so back-to-back words need no extra assignment in one time step.
  task automatic send_word(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Sends every queued character; the final one carries in_last if asked.
  task automatic send_text(input logic ends);
    logic [7:0] c;
    while (text_q.size() > 0) begin
      c = text_q.pop_front();
      send_word(c, ends && (text_q.size() == 0));
    end
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      text_q.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] rand_hex();
    return hex_chars[$urandom_range(hex_chars.len() - 1)];
  endfunction

  // A character that breaks an escape: a plus, another percent,
  // a high byte or a printable non-hex character.
  function automatic logic [7:0] rand_stray();
    int k;
    k = $urandom_range(3);
    if (k == 0) begin
      return CH_PLUS;
    end else if (k == 1) begin
      return CH_PERCENT;
    end else if (k == 2) begin
      return 8'($urandom_range(255, 128));
    end
    return stray_chars[$urandom_range(stray_chars.len() - 1)];
  endfunction

  // Most strings are built from well-formed parts with random content; about
  // a fifth of the parts are broken escapes, and some strings end mid-escape.
  task automatic send_random_string();
    int         parts;
    int         p;
    int         kind;
    logic [7:0] c;
    parts = $urandom_range(8, 1);
    for (p = 0; p < parts; p++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        c = 8'($urandom_range(255));
        text_q.push_back(c);
      end else if (kind < 52) begin
        text_q.push_back(CH_PLUS);
      end else if (kind < 82) begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(rand_hex());
        text_q.push_back(rand_hex());
      end else if (kind < 91) begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(rand_stray());
      end else begin
        text_q.push_back(CH_PERCENT);
        text_q.push_back(rand_hex());
        text_q.push_back(rand_stray());
      end
    end
    kind = $urandom_range(99);
    if (kind < 8) begin
      text_q.push_back(CH_PERCENT);
    end else if (kind < 14) begin
      text_q.push_back(CH_PERCENT);
      text_q.push_back(rand_hex());
    end
    send_text(1'b1);
    strings_sent++;
  endtask

  // Valid is dropped first so the word already accepted is not offered again
  // across the edge where the idle mix changes.
  task automatic set_idle(input int s, input int r);
    in_valid <= 1'b0;
    @(posedge clk);
    send_idle = s;
    recv_idle = r;
    @(negedge clk);
  endtask

  task automatic random_phase(input int n_words);
    int goal;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      send_random_string();
    end
  endtask

  initial begin
    wait (rst_n);
    @(negedge clk);

    // Directed part: byte extremes, a plus, escapes with both digit cases,
    // a percent followed by a plus, a percent followed by a percent, broken
    // escapes holding a lowercase and an uppercase digit, and strings that
    // end on a bare percent, on a held digit, on a complete escape and with
    // a percent still waiting.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    queue_text("+%41%fF%+%%30%bq%C%");
    send_text(1'b0);
    send_word(8'h78, 1'b1);
    queue_text("%");
    send_text(1'b1);
    queue_text("%7");
    send_text(1'b1);
    queue_text("%20");
    send_text(1'b1);
    strings_sent += 4;

    set_idle(35, 69);
    random_phase(PHASE_WORDS);
    set_idle(69, 35);
    random_phase(PHASE_WORDS);

    // Full rate on both sides, with the long receiver hold-off at the start
    // while the sender keeps offering words.
    set_idle(0, 0);
    hold_go = 1'b1;
    random_phase(PHASE_WORDS + 10);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d encoded words in %0d strings; checked %0d decoded words.",
             words_sent, strings_sent, checked);
    $display("Idle mixes: sender-heavy, receiver-heavy and none, plus a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches found.", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
